### rtl/tlrq_pkg.sv
package tlrq_pkg;

   localparam int CAPACITY_DEF = 64;
   localparam int ID_BITS_DEF  = 16;
   localparam int QUEUE_DEPTH  = 2;

   localparam int STAMP_BITS = 31;
   localparam int ENTRY_BITS = 16;
   localparam int GRAN_BITS  = 3;
   localparam int SEC_BITS   = 31;
   localparam int FIELD_BITS = 7;
   localparam int NUM_FIELDS = 6;

   typedef logic [SEC_BITS-1:0] secs_type;

   localparam secs_type SEC_MINUTE = secs_type'(60);
   localparam secs_type SEC_HOUR   = secs_type'(60 * 60);
   localparam secs_type SEC_DAY    = secs_type'(24 * 60 * 60);
   localparam secs_type SEC_MONTH  = secs_type'(31 * 24 * 60 * 60);
   localparam secs_type SEC_YEAR   = secs_type'(12 * 31 * 24 * 60 * 60);

   localparam secs_type SEC_WEIGHT [NUM_FIELDS] =
      '{SEC_YEAR, SEC_MONTH, SEC_DAY, SEC_HOUR, SEC_MINUTE, secs_type'(1)};

   typedef enum logic {
      CMD_PUT      = 1'b0,
      CMD_RETRIEVE = 1'b1
   } cmd_type;

   typedef enum logic [GRAN_BITS-1:0] {
      GRAN_YEAR   = 3'd0,
      GRAN_MONTH  = 3'd1,
      GRAN_DAY    = 3'd2,
      GRAN_HOUR   = 3'd3,
      GRAN_MINUTE = 3'd4,
      GRAN_SECOND = 3'd5
   } gran_type;

   typedef logic [NUM_FIELDS-1:0][FIELD_BITS-1:0] fields_type;

   typedef struct packed {
      cmd_type                 cmd;
      logic [ENTRY_BITS-1:0]   id;
      secs_type                lo;
      secs_type                hi;
   } job_type;

   typedef enum logic [1:0] {
      F_IDLE,
      F_MUL,
      F_SUM,
      F_PUSH
   } front_state_type;

   typedef enum logic [1:0] {
      B_IDLE,
      B_PUT,
      B_SCAN,
      B_DONE
   } back_state_type;

endpackage

### rtl/tlrq_if.sv
interface tlrq_req_if import tlrq_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic                    command;
   logic [ENTRY_BITS-1:0]   entry_id;
   logic [STAMP_BITS-1:0]   time_a;
   logic [STAMP_BITS-1:0]   time_b;
   logic [GRAN_BITS-1:0]    granularity;

   modport source (output valid, command, entry_id, time_a, time_b, granularity,
                   input ready);
   modport sink (input valid, command, entry_id, time_a, time_b, granularity,
                 output ready);
endinterface

interface tlrq_rsp_if import tlrq_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [ENTRY_BITS-1:0]   match_id;
   logic                    has_id;
   logic                    last;
   logic                    dropped;

   modport source (output valid, match_id, has_id, last, dropped, input ready);
   modport sink (input valid, match_id, has_id, last, dropped, output ready);
endinterface

### rtl/tlrq_ram.sv
module tlrq_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/tlrq_front.sv
module tlrq_front import tlrq_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   tlrq_req_if.sink    req,
   output logic        push,
   output job_type     push_job,
   input  logic        full
);

   front_state_type         state_ff, state_in;
   cmd_type                 cmd_ff, cmd_in;
   logic [ENTRY_BITS-1:0]   id_ff, id_in;
   logic [STAMP_BITS-1:0]   ta_ff, ta_in;
   logic [STAMP_BITS-1:0]   tb_ff, tb_in;
   logic [GRAN_BITS-1:0]    gran_ff, gran_in;
   secs_type                prod_a_ff [NUM_FIELDS];
   secs_type                prod_a_in [NUM_FIELDS];
   secs_type                prod_b_ff [NUM_FIELDS];
   secs_type                prod_b_in [NUM_FIELDS];
   secs_type                sum_a_ff [3];
   secs_type                sum_a_in [3];
   secs_type                sum_b_ff [3];
   secs_type                sum_b_in [3];
   fields_type              fa;
   fields_type              fb;
   logic [GRAN_BITS-1:0]    gran_a;

   // unpack, clear fields below the granularity, raise the end field, rebase month and day
   function automatic fields_type bound_fields(logic [STAMP_BITS-1:0] stamp,
                                               logic [GRAN_BITS-1:0] gran,
                                               logic raise);
      fields_type            f;
      logic [GRAN_BITS-1:0]  g;
      f[0] = FIELD_BITS'(stamp[30:26]);
      f[1] = FIELD_BITS'(stamp[25:22]);
      f[2] = FIELD_BITS'(stamp[21:17]);
      f[3] = FIELD_BITS'(stamp[16:12]);
      f[4] = FIELD_BITS'(stamp[11:6]);
      f[5] = FIELD_BITS'(stamp[5:0]);
      g = (gran > GRAN_SECOND) ? GRAN_YEAR : gran;
      for (int i = 0; i < NUM_FIELDS; i++) begin
         if (i > int'(g)) begin
            f[i] = '0;
         end
      end
      if (raise) begin
         f[g] = f[g] + FIELD_BITS'(1);
      end
      if (f[1] != '0) begin
         f[1] = f[1] - FIELD_BITS'(1);
      end
      if (f[2] != '0) begin
         f[2] = f[2] - FIELD_BITS'(1);
      end
      return f;
   endfunction

   assign req.ready = (state_ff == F_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      id_in    = id_ff;
      ta_in    = ta_ff;
      tb_in    = tb_ff;
      gran_in  = gran_ff;
      prod_a_in = prod_a_ff;
      prod_b_in = prod_b_ff;
      sum_a_in  = sum_a_ff;
      sum_b_in  = sum_b_ff;
      push      = 1'b0;
      push_job.cmd = cmd_ff;
      push_job.id  = id_ff;
      push_job.lo  = sum_a_ff[0] + sum_a_ff[1] + sum_a_ff[2];
      push_job.hi  = sum_b_ff[0] + sum_b_ff[1] + sum_b_ff[2];
      gran_a = (cmd_ff == CMD_PUT) ? GRAN_SECOND : gran_ff;
      fa = bound_fields(ta_ff, gran_a, 1'b0);
      fb = bound_fields(tb_ff, gran_ff, 1'b1);

      unique case (state_ff)
         F_IDLE: begin
            if (req.valid) begin
               cmd_in   = cmd_type'(req.command);
               id_in    = req.entry_id;
               ta_in    = req.time_a;
               tb_in    = req.time_b;
               gran_in  = req.granularity;
               state_in = F_MUL;
            end
         end
         F_MUL: begin
            for (int k = 0; k < NUM_FIELDS; k++) begin
               prod_a_in[k] = secs_type'(secs_type'(fa[k]) * SEC_WEIGHT[k]);
               prod_b_in[k] = secs_type'(secs_type'(fb[k]) * SEC_WEIGHT[k]);
            end
            state_in = F_SUM;
         end
         F_SUM: begin
            for (int j = 0; j < 3; j++) begin
               sum_a_in[j] = prod_a_ff[2*j] + prod_a_ff[2*j+1];
               sum_b_in[j] = prod_b_ff[2*j] + prod_b_ff[2*j+1];
            end
            state_in = F_PUSH;
         end
         F_PUSH: begin
            if (!full) begin
               push     = 1'b1;
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      id_ff     <= id_in;
      ta_ff     <= ta_in;
      tb_ff     <= tb_in;
      gran_ff   <= gran_in;
      prod_a_ff <= prod_a_in;
      prod_b_ff <= prod_b_in;
      sum_a_ff  <= sum_a_in;
      sum_b_ff  <= sum_b_in;
   end

endmodule

### rtl/tlrq_queue.sv
module tlrq_queue import tlrq_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  job_type  push_job,
   output logic     full,
   input  logic     pop,
   output job_type  pop_job,
   output logic     pop_valid
);

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int NW = $clog2(QUEUE_DEPTH + 1);

   job_type           slot_ff [QUEUE_DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0]     fill_ff, fill_in;

   function automatic logic [PW-1:0] bump(logic [PW-1:0] p);
      return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
   endfunction

   assign full      = (fill_ff == NW'(QUEUE_DEPTH));
   assign pop_valid = (fill_ff != '0);
   assign pop_job   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !full) begin
         wr_ptr_in = bump(wr_ptr_ff);
      end
      if (pop && pop_valid) begin
         rd_ptr_in = bump(rd_ptr_ff);
      end
      if ((push && !full) && !(pop && pop_valid)) begin
         fill_in = fill_ff + NW'(1);
      end else if (!(push && !full) && (pop && pop_valid)) begin
         fill_in = fill_ff - NW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push && !full) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

### rtl/tlrq_back.sv
module tlrq_back import tlrq_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEF,
   parameter int ID_BITS  = ID_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        q_valid,
   input  job_type     q_job,
   output logic        q_pop,
   tlrq_rsp_if.source  rsp
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   back_state_type          state_ff, state_in;
   logic [CW-1:0]           count_ff, count_in;
   logic [CW-1:0]           idx_ff, idx_in;
   logic                    dv_ff, dv_in;
   secs_type                lo_ff, lo_in;
   secs_type                hi_ff, hi_in;
   logic [ENTRY_BITS-1:0]   jid_ff, jid_in;
   logic [ENTRY_BITS-1:0]   pend_ff, pend_in;
   logic                    pend_v_ff, pend_v_in;
   logic                    out_v_ff, out_v_in;
   logic [ENTRY_BITS-1:0]   out_id_ff, out_id_in;
   logic                    out_has_ff, out_has_in;
   logic                    out_last_ff, out_last_in;
   logic                    out_drop_ff, out_drop_in;

   logic                          wr_en;
   logic                          rd_en;
   secs_type                      rd_sec;
   logic [ID_BITS-1:0]            rd_id;
   logic [ID_BITS-1:0]            wr_id;
   logic [ID_BITS+ENTRY_BITS-1:0] id_wide_rd;
   logic [ID_BITS+ENTRY_BITS-1:0] id_wide_wr;
   logic [ENTRY_BITS-1:0]         rd_id16;
   logic                          can_load;
   logic                          hit;

   assign id_wide_rd = {{ENTRY_BITS{1'b0}}, rd_id};
   assign rd_id16    = id_wide_rd[ENTRY_BITS-1:0];
   assign id_wide_wr = {{ID_BITS{1'b0}}, jid_ff};
   assign wr_id      = id_wide_wr[ID_BITS-1:0];

   tlrq_ram #(.WIDTH(SEC_BITS), .DEPTH(CAPACITY)) u_sec_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (lo_ff),
      .rd_en   (rd_en),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (rd_sec)
   );

   tlrq_ram #(.WIDTH(ID_BITS), .DEPTH(CAPACITY)) u_id_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (wr_id),
      .rd_en   (rd_en),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (rd_id)
   );

   assign can_load = !out_v_ff || rsp.ready;
   assign hit      = dv_ff && (rd_sec >= lo_ff) && (rd_sec < hi_ff);

   assign rsp.valid    = out_v_ff;
   assign rsp.match_id = out_id_ff;
   assign rsp.has_id   = out_has_ff;
   assign rsp.last     = out_last_ff;
   assign rsp.dropped  = out_drop_ff;

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      idx_in      = idx_ff;
      dv_in       = dv_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      jid_in      = jid_ff;
      pend_in     = pend_ff;
      pend_v_in   = pend_v_ff;
      out_v_in    = out_v_ff && !rsp.ready;
      out_id_in   = out_id_ff;
      out_has_in  = out_has_ff;
      out_last_in = out_last_ff;
      out_drop_in = out_drop_ff;
      q_pop       = 1'b0;
      wr_en       = 1'b0;
      rd_en       = 1'b0;

      unique case (state_ff)
         B_IDLE: begin
            if (q_valid) begin
               q_pop  = 1'b1;
               lo_in  = q_job.lo;
               hi_in  = q_job.hi;
               jid_in = q_job.id;
               if (q_job.cmd == CMD_PUT) begin
                  state_in = B_PUT;
               end else begin
                  idx_in    = '0;
                  dv_in     = 1'b0;
                  pend_v_in = 1'b0;
                  state_in  = B_SCAN;
               end
            end
         end
         B_PUT: begin
            if (can_load) begin
               out_v_in    = 1'b1;
               out_id_in   = '0;
               out_has_in  = 1'b0;
               out_last_in = 1'b1;
               out_drop_in = (count_ff == CW'(CAPACITY));
               if (count_ff != CW'(CAPACITY)) begin
                  wr_en    = 1'b1;
                  count_in = count_ff + CW'(1);
               end
               state_in = B_IDLE;
            end
         end
         B_SCAN: begin
            // hold the read while an older match cannot leave
            if (!(hit && pend_v_ff && !can_load)) begin
               if (hit) begin
                  if (pend_v_ff) begin
                     out_v_in    = 1'b1;
                     out_id_in   = pend_ff;
                     out_has_in  = 1'b1;
                     out_last_in = 1'b0;
                     out_drop_in = 1'b0;
                  end
                  pend_in   = rd_id16;
                  pend_v_in = 1'b1;
               end
               if (idx_ff < count_ff) begin
                  rd_en  = 1'b1;
                  dv_in  = 1'b1;
                  idx_in = idx_ff + CW'(1);
               end else begin
                  dv_in = 1'b0;
                  if (!dv_ff) begin
                     state_in = B_DONE;
                  end
               end
            end
         end
         B_DONE: begin
            if (can_load) begin
               out_v_in    = 1'b1;
               out_id_in   = pend_v_ff ? pend_ff : '0;
               out_has_in  = pend_v_ff;
               out_last_in = 1'b1;
               out_drop_in = 1'b0;
               pend_v_in   = 1'b0;
               state_in    = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= B_IDLE;
         count_ff  <= '0;
         idx_ff    <= '0;
         dv_ff     <= 1'b0;
         pend_v_ff <= 1'b0;
         out_v_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         idx_ff    <= idx_in;
         dv_ff     <= dv_in;
         pend_v_ff <= pend_v_in;
         out_v_ff  <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      jid_ff      <= jid_in;
      pend_ff     <= pend_in;
      out_id_ff   <= out_id_in;
      out_has_ff  <= out_has_in;
      out_last_ff <= out_last_in;
      out_drop_ff <= out_drop_in;
   end

endmodule

### rtl/timestamp_log_range_query.sv
// Log store with time-range query.
// req_chan carries one request: command put (entry_id and stamp in time_a) or
// retrieve (time_a start, time_b end, granularity). Stamps are packed calendar
// fields and are reduced to seconds in the front section (F_MUL, F_SUM), then
// queued in a two-entry job queue for the back section.
// rsp_chan returns one acknowledgement per put (dropped set when the store
// holds CAPACITY entries) and, per retrieve, the ids of all matching entries
// in insertion order with last on the final one, or one empty result.
// A retrieve scans the stored entries one per cycle through the read port of
// the entry RAMs, while no new match waits on an older one that cannot leave.
// The front section takes a new request only once it has pushed the last one
// into the queue, which waits while the queue is full, so requests overlap the
// scan of an earlier retrieve. Reset empties the store (entry count zero); the
// RAM contents are not cleared and there is no clearing pass. When rsp_chan is
// stalled the result register holds its value, the scan pauses when a new match
// finds an older one held, and requests back up into the queue.
module timestamp_log_range_query import tlrq_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEF,
   parameter int ID_BITS  = ID_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   tlrq_req_if.sink    req_chan,
   tlrq_rsp_if.source  rsp_chan
);

   logic     push;
   job_type  push_job;
   logic     full;
   logic     q_pop;
   job_type  q_job;
   logic     q_valid;

   tlrq_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req      (req_chan),
      .push     (push),
      .push_job (push_job),
      .full     (full)
   );

   tlrq_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .full      (full),
      .pop       (q_pop),
      .pop_job   (q_job),
      .pop_valid (q_valid)
   );

   tlrq_back #(.CAPACITY(CAPACITY), .ID_BITS(ID_BITS)) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_job   (q_job),
      .q_pop   (q_pop),
      .rsp     (rsp_chan)
   );

endmodule

### test/tb.sv
`timescale 1ns / 1ps

module tb;
   import tlrq_pkg::*;

   localparam logic [GRAN_BITS-1:0] GRAN_UNDEF_LO = 3'd6;
   localparam logic [GRAN_BITS-1:0] GRAN_UNDEF_HI = 3'd7;
   localparam logic [STAMP_BITS-1:0] STAMP_MAX = 31'h7FFF_FFFF;

   localparam longint unsigned SECS_MINUTE = 60;
   localparam longint unsigned SECS_HOUR   = 60 * 60;
   localparam longint unsigned SECS_DAY    = 24 * 60 * 60;
   localparam longint unsigned SECS_MONTH  = 31 * 24 * 60 * 60;
   localparam longint unsigned SECS_YEAR   = 12 * 31 * 24 * 60 * 60;

   typedef struct packed {
      logic [ENTRY_BITS-1:0] match_id;
      logic                  has_id;
      logic                  last;
      logic                  dropped;
   } result_type;

   logic clock;
   logic reset;
   logic sink_ready = 1'b0;
   int   stall_left;
   bit   idle_on;
   bit   stalls_on;
   int   error_count;

   logic [STAMP_BITS-1:0] stamp_log [CAPACITY_DEF];
   logic [ENTRY_BITS-1:0] id_log [CAPACITY_DEF];
   int                    log_count;
   result_type            pending_results [$];

   tlrq_req_if req_chan ();
   tlrq_rsp_if rsp_chan ();

   assign rsp_chan.ready = sink_ready;

   timestamp_log_range_query dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver stalls in bursts of random length while stalls_on is set
   always @(posedge clock) begin
      if (reset) begin
         sink_ready <= 1'b1;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end else if (stalls_on && $urandom_range(0, 7) == 0) begin
         sink_ready <= 1'b0;
         stall_left <= $urandom_range(0, 6);
      end else begin
         sink_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : check_results
      result_type seen;
      result_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         seen = {rsp_chan.match_id, rsp_chan.has_id, rsp_chan.last, rsp_chan.dropped};
         if (pending_results.size() == 0) begin
            error_count++;
            $display("%0t: unexpected result: id %h has %b last %b dropped %b",
                     $time, seen.match_id, seen.has_id, seen.last, seen.dropped);
         end else begin
            want = pending_results.pop_front();
            if (seen.match_id !== want.match_id || seen.has_id !== want.has_id ||
                seen.last !== want.last || seen.dropped !== want.dropped) begin
               error_count++;
               $display("%0t: mismatch: expected id %h has %b last %b dropped %b, %s",
                        $time, want.match_id, want.has_id, want.last, want.dropped,
                        $sformatf("actual id %h has %b last %b dropped %b",
                                  seen.match_id, seen.has_id, seen.last, seen.dropped));
            end
         end
      end
   end

   function automatic logic [STAMP_BITS-1:0] make_stamp(input int yoff, input int mon,
                                                        input int day, input int hr,
                                                        input int mn, input int sc);
      return {5'(yoff), 4'(mon), 5'(day), 5'(hr), 6'(mn), 6'(sc)};
   endfunction

   // seconds of a stamp cut to a granularity; the end bound is raised by one unit
   function automatic longint unsigned calendar_seconds(input logic [STAMP_BITS-1:0] stamp,
                                                        input logic [GRAN_BITS-1:0] gran,
                                                        input bit is_end);
      longint unsigned f [6];
      longint unsigned m;
      longint unsigned d;
      int              g;
      int              i;
      f[0] = stamp[30:26];
      f[1] = stamp[25:22];
      f[2] = stamp[21:17];
      f[3] = stamp[16:12];
      f[4] = stamp[11:6];
      f[5] = stamp[5:0];
      g = (gran > GRAN_SECOND) ? GRAN_YEAR : gran;
      for (i = g + 1; i < 6; i++)
         f[i] = 0;
      if (is_end)
         f[g] = f[g] + 1;
      m = (f[1] != 0) ? f[1] - 1 : 0;
      d = (f[2] != 0) ? f[2] - 1 : 0;
      return f[0] * SECS_YEAR + m * SECS_MONTH + d * SECS_DAY
           + f[3] * SECS_HOUR + f[4] * SECS_MINUTE + f[5];
   endfunction

   function automatic logic [STAMP_BITS-1:0] random_stamp();
      if ($urandom_range(0, 3) == 0)
         return STAMP_BITS'($urandom);
      return make_stamp($urandom_range(0, 3), $urandom_range(0, 15), $urandom_range(0, 31),
                        $urandom_range(0, 31), $urandom_range(0, 63), $urandom_range(0, 63));
   endfunction

   function automatic logic [STAMP_BITS-1:0] pick_stamp();
      if (log_count > 0 && $urandom_range(0, 3) != 0)
         return stamp_log[$urandom_range(0, log_count - 1)];
      return random_stamp();
   endfunction

   task automatic issue_request(input logic cmd, input logic [ENTRY_BITS-1:0] id,
                                input logic [STAMP_BITS-1:0] time_start,
                                input logic [STAMP_BITS-1:0] time_end,
                                input logic [GRAN_BITS-1:0] gran);
      longint unsigned       lo;
      longint unsigned       hi;
      longint unsigned       c;
      logic [ENTRY_BITS-1:0] hit_ids [$];
      result_type            r;
      int                    i;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.command     <= cmd;
      req_chan.entry_id    <= id;
      req_chan.time_a      <= time_start;
      req_chan.time_b      <= time_end;
      req_chan.granularity <= gran;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);

      r = '0;
      if (cmd == CMD_PUT) begin
         r.last = 1'b1;
         if (log_count >= CAPACITY_DEF) begin
            r.dropped = 1'b1;
         end else begin
            stamp_log[log_count] = time_start;
            id_log[log_count] = id;
            log_count++;
         end
         pending_results = {pending_results, r};
      end else begin
         lo = calendar_seconds(time_start, gran, 1'b0);
         hi = calendar_seconds(time_end, gran, 1'b1);
         for (i = 0; i < log_count; i++) begin
            c = calendar_seconds(stamp_log[i], GRAN_SECOND, 1'b0);
            if (c >= lo && c < hi)
               hit_ids = {hit_ids, id_log[i]};
         end
         if (hit_ids.size() == 0) begin
            r.last = 1'b1;
            pending_results = {pending_results, r};
         end else begin
            for (i = 0; i < hit_ids.size(); i++) begin
               r.match_id = hit_ids[i];
               r.has_id = 1'b1;
               r.last = (i == hit_ids.size() - 1);
               pending_results = {pending_results, r};
            end
         end
      end
   endtask

   task automatic random_put();
      issue_request(CMD_PUT, ENTRY_BITS'($urandom), random_stamp(),
                    STAMP_BITS'($urandom), GRAN_BITS'($urandom));
   endtask

   task automatic random_retrieve();
      logic [STAMP_BITS-1:0] a;
      logic [STAMP_BITS-1:0] b;
      logic [STAMP_BITS-1:0] t;
      logic [GRAN_BITS-1:0]  g;
      a = pick_stamp();
      b = pick_stamp();
      // mostly ordered ranges, some reversed
      if ($urandom_range(0, 4) != 0 &&
          calendar_seconds(a, GRAN_SECOND, 1'b0) > calendar_seconds(b, GRAN_SECOND, 1'b0)) begin
         t = a;
         a = b;
         b = t;
      end
      if ($urandom_range(0, 9) == 0)
         g = GRAN_BITS'($urandom_range(GRAN_UNDEF_LO, GRAN_UNDEF_HI));
      else
         g = GRAN_BITS'($urandom_range(GRAN_YEAR, GRAN_SECOND));
      issue_request(CMD_RETRIEVE, ENTRY_BITS'($urandom), a, b, g);
   endtask

   task automatic test_empty_store();
      issue_request(CMD_RETRIEVE, 16'h0000, '0, STAMP_MAX, GRAN_YEAR);
   endtask

   task automatic test_put_extremes();
      issue_request(CMD_PUT, 16'h0000, '0, STAMP_MAX, GRAN_YEAR);
      issue_request(CMD_PUT, 16'hFFFF, STAMP_MAX, '0, GRAN_UNDEF_HI);
      issue_request(CMD_PUT, 16'h1234, make_stamp(0, 1, 1, 0, 0, 0), '0, GRAN_SECOND);
      issue_request(CMD_PUT, 16'hA5A5, make_stamp(5, 6, 15, 12, 30, 30), STAMP_MAX, GRAN_DAY);
      issue_request(CMD_PUT, 16'h5A5A, make_stamp(5, 7, 1, 0, 0, 0), '0, GRAN_MONTH);
   endtask

   task automatic test_granularity_bounds();
      logic [STAMP_BITS-1:0] mid;
      int                    g;
      mid = make_stamp(5, 6, 15, 12, 30, 30);
      for (g = GRAN_YEAR; g <= GRAN_UNDEF_HI; g++)
         issue_request(CMD_RETRIEVE, 16'hFFFF, mid, mid, GRAN_BITS'(g));
      issue_request(CMD_RETRIEVE, 16'h0000, '0, STAMP_MAX, GRAN_SECOND);
      issue_request(CMD_RETRIEVE, 16'h0000, '0, '0, GRAN_YEAR);
      // zero month or day in the end bound
      issue_request(CMD_RETRIEVE, 16'h0000, make_stamp(5, 6, 0, 0, 0, 0),
                    make_stamp(5, 0, 0, 0, 0, 0), GRAN_MONTH);
      issue_request(CMD_RETRIEVE, 16'h0000, '0, make_stamp(0, 0, 9, 0, 0, 0), GRAN_MONTH);
      issue_request(CMD_RETRIEVE, 16'h0000, '0, make_stamp(0, 0, 0, 5, 0, 0), GRAN_DAY);
      issue_request(CMD_RETRIEVE, 16'h0000, '0, make_stamp(0, 1, 1, 5, 0, 0), GRAN_DAY);
      // reversed range
      issue_request(CMD_RETRIEVE, 16'h0000, STAMP_MAX, '0, GRAN_SECOND);
      // end field raised past its packed width
      issue_request(CMD_RETRIEVE, 16'h0000, make_stamp(31, 0, 0, 0, 0, 0), STAMP_MAX, GRAN_YEAR);
      issue_request(CMD_RETRIEVE, 16'h0000, make_stamp(31, 15, 0, 0, 0, 0), STAMP_MAX, GRAN_MONTH);
   endtask

   task automatic test_fill_random();
      int n;
      for (n = 0; n < 150; n++) begin
         if (n % 30 == 0) begin
            idle_on = ($urandom_range(0, 2) != 0);
            stalls_on = ($urandom_range(0, 2) != 0);
         end
         if ($urandom_range(0, 1) == 0)
            random_put();
         else
            random_retrieve();
      end
   endtask

   task automatic test_full_store();
      int n;
      idle_on = 1'b1;
      stalls_on = 1'b1;
      while (log_count < CAPACITY_DEF)
         random_put();
      for (n = 0; n < 110; n++) begin
         if (n % 25 == 0) begin
            idle_on = ($urandom_range(0, 2) != 0);
            stalls_on = ($urandom_range(0, 2) != 0);
         end
         if ($urandom_range(0, 4) == 0)
            random_put();
         else
            random_retrieve();
      end
   endtask

   task automatic test_back_to_back();
      int n;
      idle_on = 1'b0;
      stalls_on = 1'b0;
      for (n = 0; n < 140; n++) begin
         if ($urandom_range(0, 1) == 0)
            random_put();
         else
            random_retrieve();
      end
   endtask

   initial begin
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.command = CMD_PUT;
      req_chan.entry_id = '0;
      req_chan.time_a = '0;
      req_chan.time_b = '0;
      req_chan.granularity = GRAN_YEAR;
      idle_on = 1'b1;
      stalls_on = 1'b1;
      error_count = 0;
      log_count = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_empty_store();
      test_put_extremes();
      test_granularity_bounds();
      test_fill_random();
      test_full_store();
      test_back_to_back();

      req_chan.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
